/* rtl/psc_pkg.sv */
// Shared constants, register codes and bundle types for the power sensor conditioning block.
`default_nettype none

package psc_pkg;

    // Sample and stream geometry
    localparam int SAMPLE_W    = 12;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_W       = 12;
    localparam int CFG_ADDR_W  = 3;

    // Block averaging of the voltages (length must be a power of two)
    localparam int BLOCK_LEN   = 32;
    localparam int BLOCK_SHIFT = $clog2(BLOCK_LEN);
    localparam int SUM_W       = SAMPLE_W + BLOCK_SHIFT;

    // First-order averaging weight (must be a power of two)
    localparam int FILTER_WEIGHT = 8;
    localparam int FILT_SHIFT    = $clog2(FILTER_WEIGHT);

    // Current conditioning
    localparam logic [SAMPLE_W-1:0] LOAD_AMP_OFFSET = 12'd0;
    localparam logic [SAMPLE_W-1:0] LOAD_AMP_FLOOR  = 12'd10;
    localparam logic [SAMPLE_W-1:0] BATT_AMP_CENTRE = 12'd2020;
    localparam logic [SAMPLE_W-1:0] DEADBAND        = 12'd10;
    localparam int                  CUR_SHIFT       = 4;

    // Alarm counters
    localparam int               ALARM_W     = 8;
    localparam logic [ALARM_W-1:0] ALARM_LIMIT = 8'd10;
    localparam int               NUM_ALARMS  = 4;

    // Scaling by constant fractions: q = (x * MULT) >> SHIFT, exact for 12-bit x
    localparam int PROD_W = 32;

    localparam int VOLT_NUM   = 100;
    localparam int VOLT_DEN   = 167;
    localparam int VOLT_SHIFT = 20;
    localparam logic [PROD_W-1:0] VOLT_MULT =
        PROD_W'((VOLT_NUM * (1 << VOLT_SHIFT) + VOLT_DEN - 1) / VOLT_DEN);

    localparam int AMP_NUM   = 10;
    localparam int AMP_DEN   = 15;
    localparam int AMP_SHIFT = 14;
    localparam logic [PROD_W-1:0] AMP_MULT =
        PROD_W'((AMP_NUM * (1 << AMP_SHIFT) + AMP_DEN - 1) / AMP_DEN);

    localparam int TEMP_NUM   = 10;
    localparam int TEMP_DEN   = 57;
    localparam int TEMP_SHIFT = 18;
    localparam logic [PROD_W-1:0] TEMP_MULT =
        PROD_W'((TEMP_NUM * (1 << TEMP_SHIFT) + TEMP_DEN - 1) / TEMP_DEN);

    localparam int TEMP_W = 10;
    localparam int BCUR_W = 8;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LOAD_VOLT_HIGH  = 3'd0,
        REG_LOAD_VOLT_LOW   = 3'd1,
        REG_BATT_VOLT_HIGH  = 3'd2,
        REG_BATT_VOLT_LOW   = 3'd3,
        REG_LOAD_CUR_LIMIT  = 3'd4,
        REG_BATT_CUR_LIMIT  = 3'd5,
        REG_OVER_VOLT_LEVEL = 3'd6,
        REG_UNDER_VOLT_LEVEL = 3'd7
    } psc_reg_t;

    // Alarm channels
    typedef enum logic [1:0] {
        ALM_LOAD_VOLT = 2'd0,
        ALM_BATT_VOLT = 2'd1,
        ALM_LOAD_AMP  = 2'd2,
        ALM_BATT_AMP  = 2'd3
    } psc_alarm_t;

    typedef struct packed {
        logic [CFG_W-1:0] load_volt_high;
        logic [CFG_W-1:0] load_volt_low;
        logic [CFG_W-1:0] batt_volt_high;
        logic [CFG_W-1:0] batt_volt_low;
        logic [CFG_W-1:0] load_current_limit;
        logic [CFG_W-1:0] batt_current_limit;
        logic [CFG_W-1:0] over_voltage_level;
        logic [CFG_W-1:0] under_voltage_level;
    } psc_cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] load_volt_avg;
        logic [SAMPLE_W-1:0] out_volt_avg;
        logic [SAMPLE_W-1:0] load_amp_filt;
        logic [SAMPLE_W-1:0] batt_amp_filt;
        logic [SAMPLE_W-1:0] temp_filt;
    } psc_state_t;

endpackage

`default_nettype wire

/* rtl/psc_front.sv */
// Input stage: load current offset, block averages of the voltages and first-order filters.
`default_nettype none

module psc_front
    import psc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // lowest bit up: load_volt_sample, out_volt_sample, load_amp_sample,
    // batt_amp_sample, temp_sample, zero fill
    input  logic [IN_TDATA_W-1:0] s_tdata,
    output logic                  st_valid,
    input  logic                  st_ready,
    output psc_state_t            st
);

    logic [SAMPLE_W-1:0]    lv;
    logic [SAMPLE_W-1:0]    ov;
    logic [SAMPLE_W-1:0]    la;
    logic [SAMPLE_W-1:0]    ba;
    logic [SAMPLE_W-1:0]    tp;
    logic [SAMPLE_W:0]      la_sub;
    logic [SAMPLE_W-1:0]    la_adj;
    logic                   accept;
    logic                   block_end;
    logic [SUM_W-1:0]       lv_sum_add;
    logic [SUM_W-1:0]       ov_sum_add;

    logic [SUM_W-1:0]       lv_sum_reg, lv_sum_next;
    logic [SUM_W-1:0]       ov_sum_reg, ov_sum_next;
    logic [BLOCK_SHIFT-1:0] count_reg, count_next;
    psc_state_t             st_reg, st_next;
    logic                   valid_reg, valid_next;

    // First-order average: (W*f - f)/W + x/W, both quotients truncated
    function automatic logic [SAMPLE_W-1:0] smooth(input logic [SAMPLE_W-1:0] f,
                                                   input logic [SAMPLE_W-1:0] x);
        logic [SAMPLE_W+FILT_SHIFT-1:0] wf;
        logic [SAMPLE_W:0]              s;
        wf = {f, {FILT_SHIFT{1'b0}}} - (SAMPLE_W + FILT_SHIFT)'(f);
        s  = (SAMPLE_W + 1)'(wf >> FILT_SHIFT) + (SAMPLE_W + 1)'(x >> FILT_SHIFT);
        return s[SAMPLE_W-1:0];
    endfunction

    // Unpack the item
    assign lv = s_tdata[0*SAMPLE_W +: SAMPLE_W];
    assign ov = s_tdata[1*SAMPLE_W +: SAMPLE_W];
    assign la = s_tdata[2*SAMPLE_W +: SAMPLE_W];
    assign ba = s_tdata[3*SAMPLE_W +: SAMPLE_W];
    assign tp = s_tdata[4*SAMPLE_W +: SAMPLE_W];

    // Take a new item when this stage is empty or its item moves on
    assign s_tready = !valid_reg || st_ready;
    assign accept   = s_tvalid && s_tready;

    // Next state for the accepted item
    always_comb begin
        // remove the offset at or above the floor, saturate at zero on borrow
        la_sub = {1'b0, la} - {1'b0, LOAD_AMP_OFFSET};
        la_adj = la;
        if (la >= LOAD_AMP_FLOOR) begin
            la_adj = la_sub[SAMPLE_W] ? '0 : la_sub[SAMPLE_W-1:0];
        end

        lv_sum_add = lv_sum_reg + SUM_W'(lv);
        ov_sum_add = ov_sum_reg + SUM_W'(ov);
        block_end  = (count_reg == BLOCK_SHIFT'(BLOCK_LEN - 1));

        st_next = st_reg;
        if (block_end) begin
            st_next.load_volt_avg = SAMPLE_W'(lv_sum_add >> BLOCK_SHIFT);
            st_next.out_volt_avg  = SAMPLE_W'(ov_sum_add >> BLOCK_SHIFT);
            lv_sum_next = '0;
            ov_sum_next = '0;
            count_next  = '0;
        end else begin
            lv_sum_next = lv_sum_add;
            ov_sum_next = ov_sum_add;
            count_next  = count_reg + BLOCK_SHIFT'(1);
        end
        st_next.load_amp_filt = smooth(st_reg.load_amp_filt, la_adj);
        st_next.batt_amp_filt = smooth(st_reg.batt_amp_filt, ba);
        st_next.temp_filt     = smooth(st_reg.temp_filt, tp);

        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (st_ready) begin
            valid_next = 1'b0;
        end
    end

    // Advance state on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_sum_reg <= '0;
            ov_sum_reg <= '0;
            count_reg  <= '0;
            st_reg     <= '0;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                lv_sum_reg <= lv_sum_next;
                ov_sum_reg <= ov_sum_next;
                count_reg  <= count_next;
                st_reg     <= st_next;
            end
        end
    end

    assign st_valid = valid_reg;
    assign st       = st_reg;

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> st_valid)
        else $error("accepted item did not reach the filter stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid && !st_ready |=> $stable(st))
        else $error("filter state changed while its item was stalled");

    a_block_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && block_end |=> count_reg == '0 && lv_sum_reg == '0 && ov_sum_reg == '0)
        else $error("block accumulators did not restart at end of block");

endmodule

`default_nettype wire

/* rtl/psc_scale.sv */
// Output stage: scaling to tenths, alarm counters, voltage flags, battery mode and result register.
`default_nettype none

module psc_scale
    import psc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  psc_cfg_t               cfg,
    input  logic                   st_valid,
    output logic                   st_ready,
    input  psc_state_t             st,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // lowest bit up: load_voltage, batt_voltage, load_current, batt_temp,
    // batt_current, discharging, over_voltage, under_voltage, load_volt_fault,
    // batt_volt_fault, load_amp_fault, batt_amp_fault, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [PROD_W-1:0]    lv_prod;
    logic [PROD_W-1:0]    bv_prod;
    logic [PROD_W-1:0]    amp_prod;
    logic [PROD_W-1:0]    temp_prod;
    logic [SAMPLE_W-1:0]  lvolt;
    logic [SAMPLE_W-1:0]  bvolt;
    logic [SAMPLE_W-1:0]  lamp;
    logic [TEMP_W-1:0]    btemp;
    logic [SAMPLE_W-1:0]  diff;
    logic [SAMPLE_W-1:0]  bcur_full;
    logic [15:0]          bcur_x10;
    logic                 disch;
    logic                 amp_latched;
    logic                 adv;
    logic [ALARM_W-1:0]   cnt_next [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] fault;

    logic [ALARM_W-1:0]   cnt_reg [NUM_ALARMS];
    logic [SAMPLE_W-1:0]  held_reg, held_next;
    logic                 ov_reg, ov_next;
    logic                 uv_reg, uv_next;
    logic [OUT_TDATA_W-1:0] result_reg, result_next;
    logic                 m_tvalid_reg;

    // Counter past the limit stays latched; otherwise count while the condition holds
    function automatic logic [ALARM_W-1:0] alarm_next(input logic [ALARM_W-1:0] cnt,
                                                      input logic cond);
        logic [ALARM_W-1:0] r;
        if (cnt > ALARM_LIMIT) begin
            r = ALARM_LIMIT + 8'd1;
        end else if (cond) begin
            r = cnt + 8'd1;
        end else begin
            r = '0;
        end
        return r;
    endfunction

    assign st_ready = !m_tvalid_reg || m_tready;
    assign adv      = st_valid && st_ready;

    // Scale by constant fractions through reciprocal multiplies
    always_comb begin
        lv_prod   = PROD_W'(st.load_volt_avg) * VOLT_MULT;
        bv_prod   = PROD_W'(st.out_volt_avg) * VOLT_MULT;
        amp_prod  = PROD_W'(st.load_amp_filt) * AMP_MULT;
        temp_prod = PROD_W'(st.temp_filt) * TEMP_MULT;
        lvolt     = SAMPLE_W'(lv_prod >> VOLT_SHIFT);
        bvolt     = SAMPLE_W'(bv_prod >> VOLT_SHIFT);
        lamp      = SAMPLE_W'(amp_prod >> AMP_SHIFT);
        btemp     = TEMP_W'(temp_prod >> TEMP_SHIFT);
    end

    // Battery mode and magnitude with deadbands
    always_comb begin
        if (st.batt_amp_filt >= BATT_AMP_CENTRE) begin
            disch = 1'b0;
            diff  = st.batt_amp_filt - BATT_AMP_CENTRE;
            if (diff < DEADBAND) begin
                diff = '0;
            end
        end else begin
            disch = 1'b1;
            diff  = BATT_AMP_CENTRE - st.batt_amp_filt;
            if (diff < DEADBAND) begin
                diff  = '0;
                disch = 1'b0;
            end
        end
        bcur_full = diff >> CUR_SHIFT;
        if (bcur_full <= 12'd1) begin
            bcur_full = '0;
        end
        if (bcur_full == '0) begin
            disch = 1'b0;
        end
        bcur_x10 = 16'(bcur_full) * 16'd10;
    end

    // Alarm counters, held load current and voltage flags
    always_comb begin
        cnt_next[ALM_LOAD_VOLT] = alarm_next(cnt_reg[ALM_LOAD_VOLT],
            lvolt >= cfg.load_volt_high || lvolt <= cfg.load_volt_low);
        cnt_next[ALM_BATT_VOLT] = alarm_next(cnt_reg[ALM_BATT_VOLT],
            bvolt >= cfg.batt_volt_high || bvolt <= cfg.batt_volt_low);
        cnt_next[ALM_LOAD_AMP]  = alarm_next(cnt_reg[ALM_LOAD_AMP],
            lamp >= cfg.load_current_limit);
        cnt_next[ALM_BATT_AMP]  = alarm_next(cnt_reg[ALM_BATT_AMP],
            bcur_x10 >= 16'(cfg.batt_current_limit));

        amp_latched = cnt_reg[ALM_LOAD_AMP] > ALARM_LIMIT;
        held_next   = held_reg;
        if (amp_latched || cnt_next[ALM_LOAD_AMP] == '0) begin
            held_next = lamp;
        end

        ov_next = ov_reg;
        uv_next = uv_reg;
        if (bvolt >= cfg.over_voltage_level) begin
            ov_next = 1'b1;
        end else if (bvolt <= cfg.under_voltage_level) begin
            uv_next = 1'b1;
        end else begin
            ov_next = 1'b0;
            uv_next = 1'b0;
        end

        fault[ALM_LOAD_VOLT] = cnt_next[ALM_LOAD_VOLT] > ALARM_LIMIT;
        fault[ALM_BATT_VOLT] = cnt_next[ALM_BATT_VOLT] > ALARM_LIMIT;
        fault[ALM_LOAD_AMP]  = cnt_next[ALM_LOAD_AMP] > ALARM_LIMIT;
        fault[ALM_BATT_AMP]  = cnt_next[ALM_BATT_AMP] > ALARM_LIMIT;

        result_next = {3'b000,
                       fault[ALM_BATT_AMP], fault[ALM_LOAD_AMP],
                       fault[ALM_BATT_VOLT], fault[ALM_LOAD_VOLT],
                       uv_next, ov_next, disch,
                       bcur_full[BCUR_W-1:0], btemp,
                       held_next, bvolt, lvolt};
    end

    // Control and running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '{default: '0};
            held_reg     <= '0;
            ov_reg       <= 1'b0;
            uv_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (adv) begin
                cnt_reg      <= cnt_next;
                held_reg     <= held_next;
                ov_reg       <= ov_next;
                uv_reg       <= uv_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (adv) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = result_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[ALM_LOAD_VOLT] <= ALARM_LIMIT + 8'd1 &&
        cnt_reg[ALM_BATT_VOLT] <= ALARM_LIMIT + 8'd1 &&
        cnt_reg[ALM_LOAD_AMP]  <= ALARM_LIMIT + 8'd1 &&
        cnt_reg[ALM_BATT_AMP]  <= ALARM_LIMIT + 8'd1)
        else $error("alarm counter ran past its latch value");

    a_latch_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[ALM_LOAD_AMP] > ALARM_LIMIT |=> cnt_reg[ALM_LOAD_AMP] == ALARM_LIMIT + 8'd1)
        else $error("latched load current alarm released");

    a_adv_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        adv |=> m_tvalid_reg)
        else $error("item left the filter stage without a result");

    a_held_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && cnt_next[ALM_LOAD_AMP] == '0 |=> held_reg == $past(lamp))
        else $error("load current not refreshed with idle alarm counter");

endmodule

`default_nettype wire

/* rtl/power_sensor_conditioning.sv */
// Top level: configuration registers, filter stage and output stage of the sensor conditioner.
//
// Usage:
//   s_* channel takes one set of five 12-bit converter samples per item.
//   m_* channel returns one conditioned result per input item, in order.
//   cfg_we/cfg_addr/cfg_wdata write the eight 12-bit thresholds; write them
//   only while no item is in flight. No read-back.
// Order: an item accepted at a clock edge updates the averages and filters
//   at that edge; its result is loaded into the output register once the
//   output stage can take it, and m_tvalid is high from then on until taken.
// Throughput: one item per cycle while m_tready stays high, set by the two
//   register stages (filter state and result register) each turning over once per cycle.
// Reset (aresetn low, synchronous): clears sums, block counter, averages,
//   filters, alarm counters, held load current and voltage flags, drops any
//   pending result and restores the register defaults.
// Stall: with m_tready low the result is held; one more item may enter the
//   filter stage, after which s_tready drops until the result is taken.
`default_nettype none

module power_sensor_conditioning
    import psc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // lowest bit up: load_volt_sample, out_volt_sample, load_amp_sample,
    // batt_amp_sample, temp_sample, zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // lowest bit up: load_voltage, batt_voltage, load_current, batt_temp,
    // batt_current, discharging, over_voltage, under_voltage, load_volt_fault,
    // batt_volt_fault, load_amp_fault, batt_amp_fault, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    psc_cfg_t   cfg_reg, cfg_next;
    psc_state_t st;
    logic       st_valid;
    logic       st_ready;

    // Register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (psc_reg_t'(cfg_addr))
                REG_LOAD_VOLT_HIGH:   cfg_next.load_volt_high      = cfg_wdata;
                REG_LOAD_VOLT_LOW:    cfg_next.load_volt_low       = cfg_wdata;
                REG_BATT_VOLT_HIGH:   cfg_next.batt_volt_high      = cfg_wdata;
                REG_BATT_VOLT_LOW:    cfg_next.batt_volt_low       = cfg_wdata;
                REG_LOAD_CUR_LIMIT:   cfg_next.load_current_limit  = cfg_wdata;
                REG_BATT_CUR_LIMIT:   cfg_next.batt_current_limit  = cfg_wdata;
                REG_OVER_VOLT_LEVEL:  cfg_next.over_voltage_level  = cfg_wdata;
                REG_UNDER_VOLT_LEVEL: cfg_next.under_voltage_level = cfg_wdata;
            endcase
        end
    end

    // Hold configuration, defaults on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.load_volt_high      <= 12'd4095;
            cfg_reg.load_volt_low       <= 12'd0;
            cfg_reg.batt_volt_high      <= 12'd4095;
            cfg_reg.batt_volt_low       <= 12'd0;
            cfg_reg.load_current_limit  <= 12'd4095;
            cfg_reg.batt_current_limit  <= 12'd4095;
            cfg_reg.over_voltage_level  <= 12'd4095;
            cfg_reg.under_voltage_level <= 12'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    psc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .st_valid (st_valid),
        .st_ready (st_ready),
        .st       (st)
    );

    psc_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .st_valid (st_valid),
        .st_ready (st_ready),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_power_sensor_conditioning.sv */
// Testbench for the power sensor conditioner: random sample runs checked against a predictor.
`timescale 1ns / 1ps

import psc_pkg::*;

// Result item layout, lowest bit up as on m_tdata
typedef struct packed {
    logic [OUT_TDATA_W-62:0] pad;
    logic                    batt_amp_fault;
    logic                    load_amp_fault;
    logic                    batt_volt_fault;
    logic                    load_volt_fault;
    logic                    under_voltage;
    logic                    over_voltage;
    logic                    discharging;
    logic [BCUR_W-1:0]       batt_current;
    logic [TEMP_W-1:0]       batt_temp;
    logic [SAMPLE_W-1:0]     load_current;
    logic [SAMPLE_W-1:0]     batt_voltage;
    logic [SAMPLE_W-1:0]     load_voltage;
} reading_t;

class cond_scoreboard;
    psc_cfg_t    cfg;
    int unsigned lv_sum, ov_sum, blk_cnt, lv_avg, ov_avg;
    int unsigned la_filt, ba_filt, tp_filt, held_la;
    int unsigned alarm_cnt [NUM_ALARMS];
    bit          ov_flag, uv_flag;
    reading_t    expected_readings [$];
    int          errors;

    function void clear();
        cfg = '1;
        cfg.load_volt_low       = '0;
        cfg.batt_volt_low       = '0;
        cfg.under_voltage_level = '0;
        lv_sum = 0; ov_sum = 0; blk_cnt = 0; lv_avg = 0; ov_avg = 0;
        la_filt = 0; ba_filt = 0; tp_filt = 0; held_la = 0;
        foreach (alarm_cnt[i]) alarm_cnt[i] = 0;
        ov_flag = 0; uv_flag = 0;
        expected_readings.delete();
        errors = 0;
    endfunction

    function void set_reg(psc_reg_t r, logic [CFG_W-1:0] v);
        case (r)
            REG_LOAD_VOLT_HIGH:   cfg.load_volt_high      = v;
            REG_LOAD_VOLT_LOW:    cfg.load_volt_low       = v;
            REG_BATT_VOLT_HIGH:   cfg.batt_volt_high      = v;
            REG_BATT_VOLT_LOW:    cfg.batt_volt_low       = v;
            REG_LOAD_CUR_LIMIT:   cfg.load_current_limit  = v;
            REG_BATT_CUR_LIMIT:   cfg.batt_current_limit  = v;
            REG_OVER_VOLT_LEVEL:  cfg.over_voltage_level  = v;
            REG_UNDER_VOLT_LEVEL: cfg.under_voltage_level = v;
        endcase
    endfunction

    // First-order average with weight 1/FILTER_WEIGHT, both divisions truncating
    function int unsigned smooth(int unsigned f, int unsigned x);
        return ((FILTER_WEIGHT * f - f) / FILTER_WEIGHT + x / FILTER_WEIGHT)
               & ((1 << SAMPLE_W) - 1);
    endfunction

    // Advance one alarm counter; returns 1 when it was already latched
    function bit step_alarm(psc_alarm_t ch, bit cond);
        if (alarm_cnt[ch] > ALARM_LIMIT) begin
            alarm_cnt[ch] = ALARM_LIMIT + 1;
            return 1'b1;
        end
        alarm_cnt[ch] = cond ? ((alarm_cnt[ch] + 1) & 8'hFF) : 0;
        return 1'b0;
    endfunction

    // Predict the reading caused by one accepted sample set
    function void note_samples(logic [IN_TDATA_W-1:0] d);
        int unsigned lv, ov, la, ba, tp;
        int unsigned lvolt, bvolt, lamp, btemp, diff, bcur;
        bit          disch, latched, dummy;
        reading_t    r;
        lv = d[0 +: SAMPLE_W];
        ov = d[SAMPLE_W +: SAMPLE_W];
        la = d[2*SAMPLE_W +: SAMPLE_W];
        ba = d[3*SAMPLE_W +: SAMPLE_W];
        tp = d[4*SAMPLE_W +: SAMPLE_W];

        // offset removal, saturating at zero, only at or above the floor
        if (la >= LOAD_AMP_FLOOR)
            la = (la >= LOAD_AMP_OFFSET) ? la - LOAD_AMP_OFFSET : 0;

        // block averages of the voltages
        lv_sum += lv;
        ov_sum += ov;
        blk_cnt++;
        if (blk_cnt >= BLOCK_LEN) begin
            lv_avg = (lv_sum / BLOCK_LEN) & ((1 << SAMPLE_W) - 1);
            ov_avg = (ov_sum / BLOCK_LEN) & ((1 << SAMPLE_W) - 1);
            blk_cnt = 0;
            lv_sum = 0;
            ov_sum = 0;
        end

        la_filt = smooth(la_filt, la);
        ba_filt = smooth(ba_filt, ba);
        tp_filt = smooth(tp_filt, tp);

        lvolt = lv_avg * VOLT_NUM / VOLT_DEN;
        dummy = step_alarm(ALM_LOAD_VOLT,
                           lvolt >= cfg.load_volt_high || lvolt <= cfg.load_volt_low);
        bvolt = ov_avg * VOLT_NUM / VOLT_DEN;
        dummy = step_alarm(ALM_BATT_VOLT,
                           bvolt >= cfg.batt_volt_high || bvolt <= cfg.batt_volt_low);

        // sticky voltage flags
        if (bvolt >= cfg.over_voltage_level) begin
            ov_flag = 1'b1;
        end else if (bvolt <= cfg.under_voltage_level) begin
            uv_flag = 1'b1;
        end else begin
            ov_flag = 1'b0;
            uv_flag = 1'b0;
        end

        // hold the reported load current while its alarm count runs
        lamp = la_filt * AMP_NUM / AMP_DEN;
        latched = step_alarm(ALM_LOAD_AMP, lamp >= cfg.load_current_limit);
        if (latched || alarm_cnt[ALM_LOAD_AMP] == 0)
            held_la = lamp & 12'hFFF;

        btemp = tp_filt * TEMP_NUM / TEMP_DEN;

        // charge or discharge around the centre, with deadbands
        if (ba_filt >= BATT_AMP_CENTRE) begin
            disch = 1'b0;
            diff = ba_filt - BATT_AMP_CENTRE;
            if (diff < DEADBAND) diff = 0;
        end else begin
            disch = 1'b1;
            diff = BATT_AMP_CENTRE - ba_filt;
            if (diff < DEADBAND) begin
                diff = 0;
                disch = 1'b0;
            end
        end
        bcur = diff >> CUR_SHIFT;
        if (bcur <= 1) bcur = 0;
        if (bcur == 0) disch = 1'b0;
        dummy = step_alarm(ALM_BATT_AMP, 10 * bcur >= cfg.batt_current_limit);

        r = '0;
        r.load_voltage    = lvolt[SAMPLE_W-1:0];
        r.batt_voltage    = bvolt[SAMPLE_W-1:0];
        r.load_current    = held_la[SAMPLE_W-1:0];
        r.batt_temp       = btemp[TEMP_W-1:0];
        r.batt_current    = bcur[BCUR_W-1:0];
        r.discharging     = disch;
        r.over_voltage    = ov_flag;
        r.under_voltage   = uv_flag;
        r.load_volt_fault = alarm_cnt[ALM_LOAD_VOLT] > ALARM_LIMIT;
        r.batt_volt_fault = alarm_cnt[ALM_BATT_VOLT] > ALARM_LIMIT;
        r.load_amp_fault  = alarm_cnt[ALM_LOAD_AMP] > ALARM_LIMIT;
        r.batt_amp_fault  = alarm_cnt[ALM_BATT_AMP] > ALARM_LIMIT;
        expected_readings.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 50)
            $display("%0t: %s: got %0h expected %0h", $time, what, got, want);
    endtask

    task cmp_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) report_mismatch(name, 64'(got), 64'(want));
    endtask

    // Compare one received reading with the oldest prediction
    task check_reading(logic [OUT_TDATA_W-1:0] d);
        reading_t got, want;
        got = d;
        if (expected_readings.size() == 0) begin
            report_mismatch("reading with none pending", d, '0);
            return;
        end
        want = expected_readings.pop_front();
        cmp_field("load_voltage",    16'(got.load_voltage),    16'(want.load_voltage));
        cmp_field("batt_voltage",    16'(got.batt_voltage),    16'(want.batt_voltage));
        cmp_field("load_current",    16'(got.load_current),    16'(want.load_current));
        cmp_field("batt_temp",       16'(got.batt_temp),       16'(want.batt_temp));
        cmp_field("batt_current",    16'(got.batt_current),    16'(want.batt_current));
        cmp_field("discharging",     16'(got.discharging),     16'(want.discharging));
        cmp_field("over_voltage",    16'(got.over_voltage),    16'(want.over_voltage));
        cmp_field("under_voltage",   16'(got.under_voltage),   16'(want.under_voltage));
        cmp_field("load_volt_fault", 16'(got.load_volt_fault), 16'(want.load_volt_fault));
        cmp_field("batt_volt_fault", 16'(got.batt_volt_fault), 16'(want.batt_volt_fault));
        cmp_field("load_amp_fault",  16'(got.load_amp_fault),  16'(want.load_amp_fault));
        cmp_field("batt_amp_fault",  16'(got.batt_amp_fault),  16'(want.batt_amp_fault));
        cmp_field("zero fill",       16'(got.pad),             16'(want.pad));
    endtask
endclass

module tb_power_sensor_conditioning;

    localparam int NUM_PHASES      = 7;
    localparam int SETS_PER_PHASE  = 105;
    localparam int PRESSURE_PHASE  = 4;
    localparam int PRESSURE_CYCLES = 300;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    cond_scoreboard sb;

    int send_idle_pct;
    int stall_pct;
    int hold_cycles;

    // Sample run state: targets held over a run so the averages settle
    logic [SAMPLE_W-1:0] run_target [5];
    int                  run_left;
    int                  run_spread;
    bit                  run_noise;

    power_sensor_conditioning u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("power_sensor_conditioning: mismatch");
        $finish;
    end

    function logic [IN_TDATA_W-1:0] pack_samples(logic [SAMPLE_W-1:0] lv, logic [SAMPLE_W-1:0] ov,
                                                 logic [SAMPLE_W-1:0] la, logic [SAMPLE_W-1:0] ba,
                                                 logic [SAMPLE_W-1:0] tp);
        return {{(IN_TDATA_W - 5*SAMPLE_W){1'b0}}, tp, ba, la, ov, lv};
    endfunction

    // Next sample set: mostly runs around held targets, some pure noise runs
    function logic [IN_TDATA_W-1:0] next_samples();
        logic [SAMPLE_W-1:0] s [5];
        int                  v;
        if (run_left == 0) begin
            run_left   = $urandom_range(96, 8);
            run_noise  = ($urandom_range(4) == 0);
            run_spread = ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
            for (int i = 0; i < 5; i++) begin
                case ($urandom_range(5))
                    0:       run_target[i] = '0;
                    1:       run_target[i] = '1;
                    2:       run_target[i] = SAMPLE_W'($urandom_range(20));
                    default: run_target[i] = SAMPLE_W'($urandom_range(4095));
                endcase
            end
            // keep battery current near the centre often, to reach the deadbands
            if ($urandom_range(2) != 0)
                run_target[3] = SAMPLE_W'(int'(BATT_AMP_CENTRE) +
                                          int'($urandom_range(300)) - 150);
        end
        run_left--;
        for (int i = 0; i < 5; i++) begin
            if (run_noise) begin
                s[i] = SAMPLE_W'($urandom);
            end else begin
                v = int'(run_target[i]) + int'($urandom_range(2 * run_spread)) - run_spread;
                s[i] = (v < 0) ? '0 : (v > 4095) ? '1 : v[SAMPLE_W-1:0];
            end
        end
        return pack_samples(s[0], s[1], s[2], s[3], s[4]);
    endfunction

    // Offer one sample set, with random idle cycles ahead of it
    task automatic send_samples(input logic [IN_TDATA_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_samples(d);
        @(negedge aclk);
    endtask

    task automatic write_reg(input psc_reg_t r, input logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        sb.set_reg(r, v);
        @(negedge aclk);
    endtask

    task automatic write_config(input psc_cfg_t c);
        write_reg(REG_LOAD_VOLT_HIGH,   c.load_volt_high);
        write_reg(REG_LOAD_VOLT_LOW,    c.load_volt_low);
        write_reg(REG_BATT_VOLT_HIGH,   c.batt_volt_high);
        write_reg(REG_BATT_VOLT_LOW,    c.batt_volt_low);
        write_reg(REG_LOAD_CUR_LIMIT,   c.load_current_limit);
        write_reg(REG_BATT_CUR_LIMIT,   c.batt_current_limit);
        write_reg(REG_OVER_VOLT_LEVEL,  c.over_voltage_level);
        write_reg(REG_UNDER_VOLT_LEVEL, c.under_voltage_level);
        cfg_we <= 1'b0;
    endtask

    // Receiver: long hold-off when asked, else random stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Check every accepted result item
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            sb.check_reading(m_tdata);
    end

    initial begin
        psc_cfg_t c;
        sb = new();
        sb.clear();
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_LOAD_VOLT_HIGH;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        run_left      = 0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // drain the block before touching the registers
            while (sb.expected_readings.size() != 0) @(posedge aclk);
            @(posedge aclk);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 84; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 84; end
                default: begin send_idle_pct = 19; stall_pct = 19; end
            endcase
            if (ph == PRESSURE_PHASE)
                hold_cycles = PRESSURE_CYCLES;
            repeat (3) @(negedge aclk);

            // thresholds: reset values, random, then the all-zero and all-one extremes
            if (ph == 0) begin
                c = '1;
                c.load_volt_low       = '0;
                c.batt_volt_low       = '0;
                c.under_voltage_level = '0;
            end else if (ph == NUM_PHASES - 2) begin
                c = '0;
            end else if (ph == NUM_PHASES - 1) begin
                c = '1;
            end else begin
                c.load_volt_high      = CFG_W'($urandom_range(2600));
                c.load_volt_low       = CFG_W'($urandom_range(c.load_volt_high));
                c.batt_volt_high      = CFG_W'($urandom_range(2600));
                c.batt_volt_low       = CFG_W'($urandom_range(c.batt_volt_high));
                c.load_current_limit  = CFG_W'($urandom_range(2800));
                c.batt_current_limit  = CFG_W'($urandom_range(1300));
                c.over_voltage_level  = CFG_W'($urandom_range(2600));
                c.under_voltage_level = CFG_W'($urandom_range(c.over_voltage_level));
            end
            write_config(c);

            if (ph == 0) begin
                // field extremes and bit patterns
                send_samples(pack_samples('0, '0, '0, '0, '0));
                send_samples(pack_samples('1, '1, '1, '1, '1));
                send_samples(pack_samples(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA));
                send_samples(pack_samples(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555));
                // load current around the offset floor
                send_samples(pack_samples(12'd100, 12'd100, 12'd9, 12'd2020, 12'd500));
                send_samples(pack_samples(12'd100, 12'd100, 12'd10, 12'd2020, 12'd500));
                send_samples(pack_samples(12'd100, 12'd100, 12'd11, 12'd2020, 12'd500));
                // battery current at and around the centre and deadband edges
                send_samples(pack_samples(12'd2000, 12'd2000, 12'd0, 12'd2029, 12'd4095));
                send_samples(pack_samples(12'd2000, 12'd2000, 12'd0, 12'd2030, 12'd4095));
                send_samples(pack_samples(12'd2000, 12'd2000, 12'd0, 12'd2011, 12'd4095));
                send_samples(pack_samples(12'd2000, 12'd2000, 12'd0, 12'd2010, 12'd4095));
                send_samples(pack_samples(12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0));
                send_samples(pack_samples(12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0));
                send_samples(pack_samples(12'd4095, 12'd4095, 12'd2000, 12'd1900, 12'd57));
                send_samples(pack_samples(12'd4095, 12'd4095, 12'd2000, 12'd2100, 12'd57));
                send_samples(pack_samples(12'd1, 12'd1, 12'd1, 12'd2020, 12'd1));
            end

            repeat (SETS_PER_PHASE) send_samples(next_samples());
            s_tvalid <= 1'b0;
        end

        // let the last results drain
        while (sb.expected_readings.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("power_sensor_conditioning: match");
        end else begin
            $display("power_sensor_conditioning: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/psc_pkg.sv
rtl/psc_front.sv
rtl/psc_scale.sv
rtl/power_sensor_conditioning.sv
tb/sv/tb_power_sensor_conditioning.sv
